[hdl/swpd_pkg.sv]
package swpd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int LEN_REG_W       = 7;
    localparam int INDEX_W         = 6;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [BYTE_W-1:0]    START_FIRST_RST = 8'hFF;
    localparam logic [BYTE_W-1:0]    START_SECOND_RST = 8'hDE;
    localparam logic [BYTE_W-1:0]    END_FIRST_RST   = 8'h2F;
    localparam logic [BYTE_W-1:0]    END_SECOND_RST  = 8'h5C;
    localparam logic [LEN_REG_W-1:0] PAYLOAD_LEN_RST = 7'd34;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_FIRST  = 3'd0,
        REG_START_SECOND = 3'd1,
        REG_END_FIRST    = 3'd2,
        REG_END_SECOND   = 3'd3,
        REG_PAYLOAD_LEN  = 3'd4
    } swpd_reg_t;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_START2,
        ST_PAYLOAD,
        ST_END1,
        ST_END2
    } swpd_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] end_first;
        logic [BYTE_W-1:0] end_second;
    } swpd_sync_t;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  data;
    } swpd_result_t;

endpackage

[hdl/swpd_cfg.sv]
module swpd_cfg
    import swpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output swpd_sync_t             sync_words,
    output logic [((($clog2(MAX_PAYLOAD + 1)) > LEN_REG_W) ?
                   ($clog2(MAX_PAYLOAD + 1)) : LEN_REG_W) - 1:0] eff_len
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W = (CNT_W > LEN_REG_W) ? CNT_W : LEN_REG_W;

    swpd_sync_t             sync_reg;
    swpd_sync_t             sync_next;
    logic [LEN_REG_W-1:0]   len_reg;
    logic [LEN_REG_W-1:0]   len_next;
    logic [LEN_W-1:0]       len_wide;

    always_comb
    begin
        sync_next = sync_reg;
        len_next  = len_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_START_FIRST:  sync_next.start_first  = cfg_data;
                REG_START_SECOND: sync_next.start_second = cfg_data;
                REG_END_FIRST:    sync_next.end_first    = cfg_data;
                REG_END_SECOND:   sync_next.end_second   = cfg_data;
                REG_PAYLOAD_LEN:  len_next               = cfg_data[LEN_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg.start_first  <= START_FIRST_RST;
            sync_reg.start_second <= START_SECOND_RST;
            sync_reg.end_first    <= END_FIRST_RST;
            sync_reg.end_second   <= END_SECOND_RST;
            len_reg               <= PAYLOAD_LEN_RST;
        end
        else
        begin
            sync_reg <= sync_next;
            len_reg  <= len_next;
        end
    end

    // A zero length counts as one; lengths beyond the maximum are clamped.
    always_comb
    begin
        len_wide = LEN_W'(len_reg);
        if (len_wide == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_wide > LEN_W'(MAX_PAYLOAD))
        begin
            eff_len = LEN_W'(MAX_PAYLOAD);
        end
        else
        begin
            eff_len = len_wide;
        end
    end

    assign sync_words = sync_reg;

endmodule

[hdl/swpd_parse.sv]
module swpd_parse
    import swpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  swpd_sync_t        sync_words,
    input  logic [((($clog2(MAX_PAYLOAD + 1)) > LEN_REG_W) ?
                   ($clog2(MAX_PAYLOAD + 1)) : LEN_REG_W) - 1:0] eff_len,
    output logic              res_valid,
    output swpd_result_t      res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W = (CNT_W > LEN_REG_W) ? CNT_W : LEN_REG_W;

    swpd_state_t      state_reg;
    swpd_state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [LEN_W-1:0] count_inc;

    assign count_inc = LEN_W'(count_reg) + LEN_W'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (accept)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    if (rx_byte == sync_words.start_first)
                    begin
                        state_next = ST_START2;
                    end
                end
                ST_START2:
                begin
                    if (rx_byte == sync_words.start_second)
                    begin
                        state_next = ST_PAYLOAD;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_PAYLOAD:
                begin
                    count_next = count_inc[CNT_W-1:0];
                    if (count_inc >= eff_len)
                    begin
                        state_next = ST_END1;
                    end
                end
                ST_END1:
                begin
                    if (rx_byte == sync_words.end_first)
                    begin
                        state_next = ST_END2;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_END2:
                begin
                    state_next = ST_HUNT;
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid = 1'b0;
        res.kind  = KIND_PAYLOAD;
        res.index = '0;
        res.data  = '0;
        case (state_reg)
            ST_PAYLOAD:
            begin
                res_valid = accept;
                res.index = count_inc[INDEX_W-1:0] - INDEX_W'(1);
                res.data  = rx_byte;
            end
            ST_END2:
            begin
                res_valid = accept && (rx_byte == sync_words.end_second);
                res.kind  = KIND_DONE;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/swpd_outbuf.sv]
module swpd_outbuf
    import swpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    input  swpd_result_t res,
    input  logic         out_stall,
    output logic         out_valid,
    output swpd_result_t out_res,
    output logic         full
);

    logic         out_valid_reg;
    logic         out_valid_next;
    swpd_result_t out_reg;
    swpd_result_t out_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    swpd_result_t skid_reg;
    swpd_result_t skid_next;
    logic         out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // The skid word always sits behind the output word, so it goes out before any new result.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = res_valid;
                skid_next       = res;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign full      = skid_valid_reg;

endmodule

[hdl/sync_word_packet_deframer.sv]
// Each result is registered into the output word, or into the skid word while the
// output is held. Throughput: one word per cycle while in_stall is low; the output
// register and one skid word let input continue while a result waits, and in_stall
// rises only when both are full. Reset clears the parser to hunting and loads the
// default sync words and length; the output is empty after reset.
module sync_word_packet_deframer
    import swpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   result_kind,
    output logic [INDEX_W-1:0]     payload_index,
    output logic [BYTE_W-1:0]      payload_byte
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W = (CNT_W > LEN_REG_W) ? CNT_W : LEN_REG_W;

    swpd_sync_t       sync_words;
    logic [LEN_W-1:0] eff_len;
    logic             accept;
    logic             res_valid;
    swpd_result_t     res;
    swpd_result_t     out_res;
    logic             buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    swpd_cfg #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sync_words (sync_words),
        .eff_len    (eff_len)
    );

    swpd_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .sync_words (sync_words),
        .eff_len    (eff_len),
        .res_valid  (res_valid),
        .res        (res)
    );

    swpd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .full      (buf_full)
    );

    assign result_kind   = out_res.kind;
    assign payload_index = out_res.index;
    assign payload_byte  = out_res.data;

endmodule

[bench/sync_word_packet_deframer_tb.sv]
`timescale 1ns / 100ps

module sync_word_packet_deframer_tb;
    import swpd_pkg::*;

    localparam int REG_COUNT = 5;
    localparam int PHASE_ITEMS = 200;
    localparam int TOTAL_ITEMS = 1750;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // Tracks the parser state and configuration of the deframer and keeps the
    // results that the accepted words are due to produce, oldest first.
    class deframe_scoreboard;
        logic [BYTE_W-1:0]    start_first;
        logic [BYTE_W-1:0]    start_second;
        logic [BYTE_W-1:0]    end_first;
        logic [BYTE_W-1:0]    end_second;
        logic [LEN_REG_W-1:0] payload_len;
        swpd_state_t          parse_state;
        bit [8:0]             taken;
        swpd_result_t         due_results[$];
        int unsigned          mismatches;

        function new();
            start_first = START_FIRST_RST;
            start_second = START_SECOND_RST;
            end_first = END_FIRST_RST;
            end_second = END_SECOND_RST;
            payload_len = PAYLOAD_LEN_RST;
            parse_state = ST_HUNT;
            taken = '0;
            mismatches = 0;
        endfunction

        function int effective_len();
            int n;
            n = payload_len;
            if (n == 0)
                n = 1;
            if (n > MAX_PAYLOAD_DEF)
                n = MAX_PAYLOAD_DEF;
            return n;
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] index, logic [BYTE_W-1:0] value);
            case (index)
                REG_START_FIRST: start_first = value;
                REG_START_SECOND: start_second = value;
                REG_END_FIRST: end_first = value;
                REG_END_SECOND: end_second = value;
                REG_PAYLOAD_LEN: payload_len = value[LEN_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] value);
            swpd_result_t res;
            case (parse_state)
                ST_HUNT:
                begin
                    if (value == start_first)
                        parse_state = ST_START2;
                end
                ST_START2:
                begin
                    if (value == start_second)
                    begin
                        parse_state = ST_PAYLOAD;
                        taken = '0;
                    end
                    else
                        parse_state = ST_HUNT;
                end
                ST_PAYLOAD:
                begin
                    res.kind = KIND_PAYLOAD;
                    res.index = taken[INDEX_W-1:0];
                    res.data = value;
                    due_results.push_back(res);
                    taken = taken + 1'b1;
                    if (taken >= effective_len())
                        parse_state = ST_END1;
                end
                ST_END1:
                begin
                    if (value == end_first)
                        parse_state = ST_END2;
                    else
                        parse_state = ST_HUNT;
                end
                default:
                begin
                    parse_state = ST_HUNT;
                    if (value == end_second)
                    begin
                        res.kind = KIND_DONE;
                        res.index = '0;
                        res.data = '0;
                        due_results.push_back(res);
                    end
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [INDEX_W-1:0] index,
                                   logic [BYTE_W-1:0] data);
            swpd_result_t want;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: result_kind %0d payload_index %0d payload_byte %0h",
                       kind, index, data);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (kind !== want.kind)
            begin
                $error("result_kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (index !== want.index)
            begin
                $error("payload_index: expected %0d, got %0d", want.index, index);
                mismatches++;
            end
            if (data !== want.data)
            begin
                $error("payload_byte: expected %0h, got %0h", want.data, data);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   result_kind;
    logic [INDEX_W-1:0]     payload_index;
    logic [BYTE_W-1:0]      payload_byte;

    deframe_scoreboard sb;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    sync_word_packet_deframer dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .payload_index(payload_index),
        .payload_byte(payload_byte)
    );

    always #5 clk = ~clk;

    task automatic offer_byte(input logic [BYTE_W-1:0] value);
        if (send_gaps && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_rx_byte(value);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [BYTE_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        sb.note_config(index, value);
    endtask

    function automatic logic [BYTE_W-1:0] other_than(logic [BYTE_W-1:0] avoid);
        logic [BYTE_W-1:0] v;
        do
            v = $urandom;
        while (v == avoid);
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] payload_value();
        case ($urandom_range(7))
            0: return sb.start_first;
            1: return sb.end_first;
            2: return 8'h00;
            3: return 8'hFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_phase_config(input int phase);
        logic [BYTE_W-1:0] words [4];
        logic [BYTE_W-1:0] len_data;
        foreach (words[i])
            words[i] = $urandom;
        len_data = $urandom_range(12, 1);
        case (phase)
            0:
            begin
                words = '{START_FIRST_RST, START_SECOND_RST, END_FIRST_RST, END_SECOND_RST};
                len_data = PAYLOAD_LEN_RST;
            end
            1:
            begin
                words = '{8'h00, 8'h00, 8'h00, 8'hFF};
                len_data = 8'd1;
            end
            2:
            begin
                words = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                len_data = MAX_PAYLOAD_DEF;
            end
            3: len_data = 8'hFF;
            4: len_data = MAX_PAYLOAD_DEF + 1;
            5: len_data = 8'h80;
            default:
            begin
                if ($urandom_range(3) == 0)
                    len_data = $urandom_range(MAX_PAYLOAD_DEF, 1);
            end
        endcase
        write_reg(REG_START_FIRST, words[0]);
        write_reg(REG_START_SECOND, words[1]);
        write_reg(REG_END_FIRST, words[2]);
        write_reg(REG_END_SECOND, words[3]);
        write_reg(REG_PAYLOAD_LEN, len_data);
        write_reg($urandom_range((1 << CFG_INDEX_W) - 1, REG_COUNT), $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed frames; the rest are noise, broken sync words and
    // frames cut short, which leave the parser collecting payload.
    task automatic send_random_frame();
        int pick;
        int n;
        pick = $urandom_range(99);
        n = sb.effective_len();
        if (pick < 8)
        begin
            repeat ($urandom_range(4, 1)) offer_byte($urandom);
        end
        else
        begin
            offer_byte(sb.start_first);
            if (pick < 14)
            begin
                if (sb.start_first != sb.start_second && $urandom_range(1))
                    offer_byte(sb.start_first);
                else
                    offer_byte(other_than(sb.start_second));
            end
            else
            begin
                offer_byte(sb.start_second);
                if (pick < 20)
                    n = $urandom_range(n - 1, 0);
                repeat (n) offer_byte(payload_value());
                if (pick >= 20)
                begin
                    if (pick < 26)
                        offer_byte(other_than(sb.end_first));
                    else
                    begin
                        offer_byte(sb.end_first);
                        if (pick < 32)
                            offer_byte(other_than(sb.end_second));
                        else
                            offer_byte(sb.end_second);
                    end
                end
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= recv_gaps && ($urandom_range(99) < 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_kind, payload_index, payload_byte);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int phase;
        int phase_start;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hunting at the reset sync words: a wrong second start byte, and a
        // repeated first start byte that must not be taken as a new start.
        offer_byte(8'h00);
        offer_byte(START_FIRST_RST);
        offer_byte(8'h00);
        offer_byte(START_SECOND_RST);
        offer_byte(START_FIRST_RST);
        offer_byte(START_FIRST_RST);
        offer_byte(START_SECOND_RST);
        offer_byte(START_FIRST_RST);
        offer_byte(START_SECOND_RST);
        offer_byte(8'h00);
        offer_byte(8'hFF);
        settle();

        // The length drops below the bytes already taken in the middle of a frame.
        write_reg(REG_PAYLOAD_LEN, 8'd1);
        cfg_wr_en <= 1'b0;
        offer_byte(8'h80);
        offer_byte(END_FIRST_RST);
        offer_byte(END_SECOND_RST);
        settle();

        // A length of zero acts as one; then both kinds of end word mismatch.
        write_reg(REG_PAYLOAD_LEN, 8'h80);
        cfg_wr_en <= 1'b0;
        offer_byte(START_FIRST_RST);
        offer_byte(START_SECOND_RST);
        offer_byte(8'h7F);
        offer_byte(END_FIRST_RST);
        offer_byte(8'h00);
        offer_byte(START_FIRST_RST);
        offer_byte(START_SECOND_RST);
        offer_byte(8'h01);
        offer_byte(END_SECOND_RST);
        offer_byte(END_FIRST_RST);
        offer_byte(END_SECOND_RST);
        settle();

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            send_gaps = !(phase == 2 || phase == 3);
            recv_gaps = send_gaps;
            if (phase == 4 || phase == 8)
                hold_req = 1'b1;
            set_phase_config(phase);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_frame();
            if ($urandom_range(1))
            begin
                offer_byte(sb.start_first);
                offer_byte(sb.start_second);
                repeat ($urandom_range(3, 1)) offer_byte(payload_value());
            end
            settle();
            phase++;
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
